FILE: hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, character codes and classification helpers for the source
// text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

   // default width of the position counters
   localparam int OFFSET_BITS_DEFAULT = 16;

   // result queue depth and its pointer and count widths
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_SQUOTE = 8'h27;
   localparam logic [7:0] CHR_UNDER  = 8'h5F;
   localparam logic [7:0] CHR_LPAREN = 8'h28;
   localparam logic [7:0] CHR_RPAREN = 8'h29;
   localparam logic [7:0] CHR_LBRACK = 8'h5B;
   localparam logic [7:0] CHR_RBRACK = 8'h5D;
   localparam logic [7:0] CHR_LBRACE = 8'h7B;
   localparam logic [7:0] CHR_RBRACE = 8'h7D;

   // token kinds as they leave the block
   typedef enum logic [2:0] {
      KIND_OPEN   = 3'd0,
      KIND_CLOSE  = 3'd1,
      KIND_STRING = 3'd2,
      KIND_LABEL  = 3'd3,
      KIND_SYMBOL = 3'd4
   } kind_type;

   // scanner state, one-hot
   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_LABEL  = 4'b0010,
      MODE_STRING = 4'b0100,
      MODE_ESCAPE = 4'b1000
   } mode_type;

   // one result transaction
   typedef struct packed {
      logic [15:0] offset;
      logic [15:0] length;
      kind_type    kind;
      logic        last;
   } token_type;

   // tokens produced by one character, first one goes out first
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } scan_out_type;

   function automatic logic is_gap(input logic [7:0] c);
      return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_CR) || (c == CHR_LF);
   endfunction

   function automatic logic is_label_char(input logic [7:0] c);
      return (c == CHR_UNDER) ||
             ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h7A)) ||
             ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_open(input logic [7:0] c);
      return (c == CHR_LPAREN) || (c == CHR_LBRACK) || (c == CHR_LBRACE);
   endfunction

   function automatic logic is_close(input logic [7:0] c);
      return (c == CHR_RPAREN) || (c == CHR_RBRACK) || (c == CHR_RBRACE);
   endfunction

endpackage

FILE: hdl/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// Per-character scanner: holds the scan state and position counters and
// decodes each accepted character into zero, one or two tokens.
// ----------------------------------------------------------------------------
module stt_scan #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           char_code,
   input  logic                 stream_end,
   output stt_pkg::scan_out_type scan_out
);

   stt_pkg::mode_type        mode_ff, mode_in;
   logic                     dq_ff, dq_in;
   logic [OFFSET_BITS-1:0]   start_ff, start_in;
   logic [OFFSET_BITS-1:0]   pos_ff, pos_in;

   logic                     classify;
   logic                     a_valid, b_valid;
   stt_pkg::token_type       a_tok, b_tok;
   logic [OFFSET_BITS-1:0]   len_incl, len_excl;
   logic [7:0]               close_quote;
   logic [15:0]              pos16;

   assign len_incl    = pos_ff + OFFSET_BITS'(1) - start_ff;
   assign len_excl    = pos_ff - start_ff;
   assign close_quote = dq_ff ? stt_pkg::CHR_DQUOTE : stt_pkg::CHR_SQUOTE;
   assign pos16       = 16'(pos_ff);

   // decode the character against the current mode
   always_comb begin
      mode_in  = mode_ff;
      dq_in    = dq_ff;
      start_in = start_ff;
      classify = 1'b0;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      a_tok    = '{offset: 16'(start_ff), length: 16'(len_excl),
                   kind: stt_pkg::KIND_LABEL, last: 1'b0};
      b_tok    = '{offset: pos16, length: 16'd1,
                   kind: stt_pkg::KIND_SYMBOL, last: 1'b0};

      unique case (mode_ff)
         stt_pkg::MODE_LABEL: begin
            if (stt_pkg::is_label_char(char_code)) begin
               if (stream_end) begin
                  a_valid      = 1'b1;
                  a_tok.length = 16'(len_incl);
               end
            end else begin
               a_valid  = 1'b1;
               mode_in  = stt_pkg::MODE_IDLE;
               classify = 1'b1;
            end
         end
         stt_pkg::MODE_STRING: begin
            if (char_code == stt_pkg::CHR_BSLASH) begin
               mode_in = stt_pkg::MODE_ESCAPE;
            end else if (char_code == close_quote) begin
               a_valid      = 1'b1;
               a_tok.length = 16'(len_incl);
               a_tok.kind   = stt_pkg::KIND_STRING;
               mode_in      = stt_pkg::MODE_IDLE;
            end
         end
         stt_pkg::MODE_ESCAPE: begin
            mode_in = stt_pkg::MODE_STRING;
         end
         stt_pkg::MODE_IDLE: begin
            classify = 1'b1;
         end
         default: begin
            mode_in  = stt_pkg::MODE_IDLE;
            classify = 1'b1;
         end
      endcase

      // token of the character itself
      if (classify) begin
         priority if (stt_pkg::is_gap(char_code)) begin
            b_valid = 1'b0;
         end else if (stt_pkg::is_open(char_code)) begin
            b_valid    = 1'b1;
            b_tok.kind = stt_pkg::KIND_OPEN;
         end else if (stt_pkg::is_close(char_code)) begin
            b_valid    = 1'b1;
            b_tok.kind = stt_pkg::KIND_CLOSE;
         end else if ((char_code == stt_pkg::CHR_SQUOTE) ||
                      (char_code == stt_pkg::CHR_DQUOTE)) begin
            start_in = pos_ff;
            dq_in    = (char_code == stt_pkg::CHR_DQUOTE);
            mode_in  = stt_pkg::MODE_STRING;
         end else if (stt_pkg::is_label_char(char_code)) begin
            start_in = pos_ff;
            if (stream_end) begin
               b_valid    = 1'b1;
               b_tok.kind = stt_pkg::KIND_LABEL;
            end else begin
               mode_in = stt_pkg::MODE_LABEL;
            end
         end else begin
            b_valid = 1'b1;
         end
      end

      // end of stream restarts at offset zero
      if (stream_end) begin
         mode_in  = stt_pkg::MODE_IDLE;
         dq_in    = 1'b0;
         start_in = '0;
         pos_in   = '0;
      end else begin
         pos_in   = pos_ff + OFFSET_BITS'(1);
      end
   end

   // pack tokens in order and flag the final one
   always_comb begin
      scan_out        = '0;
      scan_out.first  = a_valid ? a_tok : b_tok;
      scan_out.second = b_tok;
      scan_out.count  = 2'(a_valid) + 2'(b_valid);
      if (a_valid && b_valid) begin
         scan_out.second.last = 1'b1;
      end else begin
         scan_out.first.last = 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stt_pkg::MODE_IDLE;
         dq_ff    <= 1'b0;
         start_ff <= '0;
         pos_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         dq_ff    <= dq_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

FILE: hdl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Small result queue: takes up to two tokens a cycle, hands one a cycle to
// the result channel as it is popped.
// ----------------------------------------------------------------------------
module stt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stt_pkg::scan_out_type push_data,
   input  logic                  pop,
   output logic                  has_room,
   output logic                  not_empty,
   output stt_pkg::token_type    head
);

   stt_pkg::token_type                  mem [stt_pkg::QUEUE_DEPTH];
   logic [stt_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [stt_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [stt_pkg::QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic [stt_pkg::QUEUE_CNT_BITS-1:0]  n_push;
   logic [stt_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_next;

   assign has_room    = count_ff <= stt_pkg::QUEUE_CNT_BITS'(stt_pkg::QUEUE_DEPTH - 2);
   assign not_empty   = count_ff != '0;
   assign head        = mem[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + stt_pkg::QUEUE_PTR_BITS'(1);

   // pointer and fill bookkeeping
   always_comb begin
      n_push    = push ? stt_pkg::QUEUE_CNT_BITS'(push_data.count) : '0;
      wr_ptr_in = wr_ptr_ff + stt_pkg::QUEUE_PTR_BITS'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + stt_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + n_push - stt_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (push && (push_data.count != 2'd0)) begin
         mem[wr_ptr_ff] <= push_data.first;
      end
      if (push && (push_data.count == 2'd2)) begin
         mem[wr_ptr_next] <= push_data.second;
      end
   end

endmodule

FILE: hdl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: one 8-bit character per transaction in, token
// offset, length and kind out.
// ----------------------------------------------------------------------------
// One character is taken per cycle while req_tready is high; its tokens
// reach the result channel the next cycle at the earliest. A character
// yields at most two tokens (a label closed by a bracket or symbol); these
// go into a four-entry result queue that drains one token per cycle, and
// req_tready drops while fewer than two entries are free. As long as
// tokens are taken as fast as they appear the queue never holds more than
// two, so the input runs at one character per cycle; under result
// back-pressure the input waits whenever three or more tokens are queued.
// Offsets and lengths count modulo 2^OFFSET_BITS and are reported in 16
// bits. A character with req_tlast set ends the stream; the next character
// starts again at offset zero, and a string still open then is dropped.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
   parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // character stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // stream_end
   // token stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] token_offset, [31:16] token_length
   output logic [2:0]  rsp_tuser,   // [2:0] token_kind
   output logic        rsp_tlast    // run_last
);

   logic                  req_fire;
   logic                  rsp_fire;
   logic                  has_room;
   stt_pkg::scan_out_type scan_out;
   stt_pkg::token_type    head;

   assign req_tready = has_room;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // character decode and scan state
   stt_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_fire),
      .char_code  (req_tdata),
      .stream_end (req_tlast),
      .scan_out   (scan_out)
   );

   // result queue
   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_data (scan_out),
      .pop       (rsp_fire),
      .has_room  (has_room),
      .not_empty (rsp_tvalid),
      .head      (head)
   );

   // result transaction fields
   assign rsp_tdata = {head.length, head.offset};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

FILE: verif/source_text_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker
// Watches both streams of the tokenizer, predicts every token from the
// accepted characters and compares each token transaction against it.
// ----------------------------------------------------------------------------
module source_text_tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_code
   input  logic        req_tlast,    // stream_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // [15:0] token_offset, [31:16] token_length
   input  logic [2:0]  rsp_tuser,    // [2:0] token_kind
   input  logic        rsp_tlast,    // run_last
   output int          mismatch_count,
   output int          tokens_pending,
   output int          tokens_checked
);

   // scanner copy, positions wrap at 16 bits
   stt_pkg::mode_type    scan_mode;
   logic                 in_double;
   logic [15:0]          open_start;
   logic [15:0]          char_pos;

   // tokens predicted but not yet seen, oldest first
   stt_pkg::token_type   expected_tokens[$];

   function automatic logic is_word_char(input logic [7:0] c);
      return (c == stt_pkg::CHR_UNDER) || (c >= "0" && c <= "9") ||
             (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic stt_pkg::token_type make_token(input logic [15:0] offs,
                                                     input logic [15:0] len,
                                                     input stt_pkg::kind_type kind);
      stt_pkg::token_type t;
      t.offset = offs;
      t.length = len;
      t.kind   = kind;
      t.last   = 1'b0;
      return t;
   endfunction

   // advance the scanner by one character and queue the tokens it closes
   function automatic void tokenize_char(input logic [7:0] c, input logic fin);
      stt_pkg::token_type found[$];
      stt_pkg::token_type t;
      logic               classify;
      classify = 1'b0;
      case (scan_mode)
         stt_pkg::MODE_LABEL: begin
            if (is_word_char(c)) begin
               if (fin)
                  found.push_back(make_token(open_start, char_pos + 16'd1 - open_start,
                                             stt_pkg::KIND_LABEL));
            end else begin
               found.push_back(make_token(open_start, char_pos - open_start,
                                          stt_pkg::KIND_LABEL));
               scan_mode = stt_pkg::MODE_IDLE;
               classify  = 1'b1;
            end
         end
         stt_pkg::MODE_STRING: begin
            if (c == stt_pkg::CHR_BSLASH) begin
               scan_mode = stt_pkg::MODE_ESCAPE;
            end else if (c == (in_double ? stt_pkg::CHR_DQUOTE : stt_pkg::CHR_SQUOTE)) begin
               found.push_back(make_token(open_start, char_pos + 16'd1 - open_start,
                                          stt_pkg::KIND_STRING));
               scan_mode = stt_pkg::MODE_IDLE;
            end
         end
         stt_pkg::MODE_ESCAPE: begin
            scan_mode = stt_pkg::MODE_STRING;
         end
         default: begin
            classify = 1'b1;
         end
      endcase

      // the character on its own, also after it closed a label
      if (classify && !(c == stt_pkg::CHR_SPACE || c == stt_pkg::CHR_TAB ||
                        c == stt_pkg::CHR_CR || c == stt_pkg::CHR_LF)) begin
         if (c == stt_pkg::CHR_LPAREN || c == stt_pkg::CHR_LBRACK ||
             c == stt_pkg::CHR_LBRACE) begin
            found.push_back(make_token(char_pos, 16'd1, stt_pkg::KIND_OPEN));
         end else if (c == stt_pkg::CHR_RPAREN || c == stt_pkg::CHR_RBRACK ||
                      c == stt_pkg::CHR_RBRACE) begin
            found.push_back(make_token(char_pos, 16'd1, stt_pkg::KIND_CLOSE));
         end else if (c == stt_pkg::CHR_SQUOTE || c == stt_pkg::CHR_DQUOTE) begin
            open_start = char_pos;
            in_double  = (c == stt_pkg::CHR_DQUOTE);
            scan_mode  = stt_pkg::MODE_STRING;
         end else if (is_word_char(c)) begin
            open_start = char_pos;
            if (fin)
               found.push_back(make_token(char_pos, 16'd1, stt_pkg::KIND_LABEL));
            else
               scan_mode = stt_pkg::MODE_LABEL;
         end else begin
            found.push_back(make_token(char_pos, 16'd1, stt_pkg::KIND_SYMBOL));
         end
      end

      // stream end drops any open string and restarts at offset zero
      if (fin) begin
         scan_mode  = stt_pkg::MODE_IDLE;
         in_double  = 1'b0;
         open_start = '0;
         char_pos   = '0;
      end else begin
         char_pos = char_pos + 16'd1;
      end

      if (found.size() > 0) begin
         t = found.pop_back();
         t.last = 1'b1;
         found.push_back(t);
      end
      foreach (found[i]) expected_tokens.push_back(found[i]);
   endfunction

   // compare token transactions first, then predict from the character transaction
   always @(posedge clock) begin : watch
      stt_pkg::token_type seen;
      stt_pkg::token_type want;
      if (reset) begin
         scan_mode      = stt_pkg::MODE_IDLE;
         in_double      = 1'b0;
         open_start     = '0;
         char_pos       = '0;
         mismatch_count = 0;
         tokens_checked = 0;
         expected_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.offset = rsp_tdata[15:0];
            seen.length = rsp_tdata[31:16];
            seen.kind   = stt_pkg::kind_type'(rsp_tuser);
            seen.last   = rsp_tlast;
            tokens_checked++;
            if (expected_tokens.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected token off=%0d len=%0d kind=%0d last=%0b",
                           $time, seen.offset, seen.length, seen.kind, seen.last);
               mismatch_count++;
            end else begin
               want = expected_tokens.pop_front();
               if (seen.offset !== want.offset || seen.length !== want.length ||
                   seen.kind !== want.kind || seen.last !== want.last) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: token mismatch", $time);
                     $display("   expected off=%0d len=%0d kind=%0d last=%0b",
                              want.offset, want.length, want.kind, want.last);
                     $display("   got      off=%0d len=%0d kind=%0d last=%0b",
                              seen.offset, seen.length, seen.kind, seen.last);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            tokenize_char(req_tdata, req_tlast);
      end
      tokens_pending = expected_tokens.size();
   end

endmodule

FILE: verif/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb
// Drives character streams into the tokenizer under several idle and stall
// mixes; the checker beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_CHARS = 320;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatch_count;
   int tokens_pending;
   int tokens_checked;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int chars_sent     = 0;
   int streams_sent   = 0;
   int cycle_count    = 0;

   logic [7:0] stream_chars[$];

   source_text_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   source_text_tokenizer_checker checker_0 (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .tokens_pending (tokens_pending),
      .tokens_checked (tokens_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // one character transaction, with random idle cycles ahead of it
   task automatic send_char(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      if (fin) streams_sent++;
   endtask

   task automatic send_text(input string text, input logic fin);
      for (int i = 0; i < text.len(); i++)
         send_char(text[i], fin && (i == text.len() - 1));
   endtask

   // hold off until every predicted token has come out
   task automatic wait_for_tokens();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tokens_pending != 0) @(posedge clock);
   endtask

   // random streams of mostly well-formed tokens with some noise
   task automatic run_phase(input int idle_pct, input int stall_pct);
      int          sent;
      int          target;
      int          pick;
      int          len;
      int          r;
      logic [7:0]  quote;
      logic [7:0]  c;
      logic [7:0]  brackets[6];
      logic [7:0]  blanks[4];
      brackets = '{stt_pkg::CHR_LPAREN, stt_pkg::CHR_RPAREN, stt_pkg::CHR_LBRACK,
                   stt_pkg::CHR_RBRACK, stt_pkg::CHR_LBRACE, stt_pkg::CHR_RBRACE};
      blanks   = '{stt_pkg::CHR_SPACE, stt_pkg::CHR_TAB, stt_pkg::CHR_CR, stt_pkg::CHR_LF};
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < PHASE_CHARS) begin
         stream_chars.delete();
         target = $urandom_range(40, 3);
         while (stream_chars.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
               stream_chars.push_back(blanks[$urandom_range(3)]);
            end else if (pick < 30) begin
               stream_chars.push_back(brackets[$urandom_range(5)]);
            end else if (pick < 55) begin
               len = $urandom_range(10, 1);
               repeat (len) begin
                  r = $urandom_range(62);
                  if (r < 26)      c = 8'("a" + r);
                  else if (r < 52) c = 8'("A" + (r - 26));
                  else if (r < 62) c = 8'("0" + (r - 52));
                  else             c = stt_pkg::CHR_UNDER;
                  stream_chars.push_back(c);
               end
            end else if (pick < 75) begin
               quote = $urandom_range(1) ? stt_pkg::CHR_DQUOTE : stt_pkg::CHR_SQUOTE;
               stream_chars.push_back(quote);
               len = $urandom_range(8);
               repeat (len) begin
                  if ($urandom_range(99) < 15) begin
                     stream_chars.push_back(stt_pkg::CHR_BSLASH);
                     stream_chars.push_back(8'($urandom_range(255)));
                  end else begin
                     c = 8'($urandom_range(255));
                     if (c == quote || c == stt_pkg::CHR_BSLASH) c = "a";
                     stream_chars.push_back(c);
                  end
               end
               // an unclosed string swallows what follows
               if ($urandom_range(9) != 0) stream_chars.push_back(quote);
            end else begin
               stream_chars.push_back(8'($urandom_range(255)));
            end
         end
         // cut some streams short, possibly inside a token
         if ($urandom_range(9) == 0)
            while (stream_chars.size() > 1 && $urandom_range(3) != 0)
               void'(stream_chars.pop_back());
         foreach (stream_chars[i])
            send_char(stream_chars[i], i == stream_chars.size() - 1);
         sent += stream_chars.size();
      end
      wait_for_tokens();
      repeat (8) @(posedge clock);
   endtask

   // main sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // brackets, blanks and symbols at the byte extremes
      send_text("([{\t}])", 1'b0);
      send_char(stt_pkg::CHR_CR, 1'b0);
      send_char(stt_pkg::CHR_LF, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(8'hFF, 1'b1);
      // labels closed by a bracket, by a symbol, and by stream end
      send_text("ab(Z+qr", 1'b1);
      // escaped quote inside a string, label closed by a blank at stream end
      send_text("'\\'\"'k ", 1'b1);
      // string left open after a trailing backslash
      send_text("\"a\\", 1'b1);
      wait_for_tokens();

      run_phase(0, 0);
      run_phase(64, 0);
      run_phase(0, 64);
      run_phase(17, 17);

      wait_for_tokens();
      repeat (20) @(posedge clock);

      $display("run covered %0d characters in %0d streams, %0d tokens compared",
               chars_sent, streams_sent, tokens_checked);
      $display("four idle and back-pressure mixes, open strings and labels at stream end");
      if (mismatch_count == 0 && tokens_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
